// ===== rtl/rsa_pkg.sv =====
// Shared types and constants for the 64-bit RSA modular exponentiation block.
package rsa_pkg;

	// Exponent registers are always 64 bits wide
	localparam int unsigned EXP_BITS  = 64;
	localparam int unsigned ECNT_W    = $clog2(EXP_BITS + 1);
	localparam int unsigned DATA_W    = 64;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_W     = 64;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODULUS  = 2'd0,
		CFG_PUB_EXP  = 2'd1,
		CFG_PRIV_EXP = 2'd2,
		CFG_DECRYPT  = 2'd3
	} rsa_cfg_idx_t;

	// Controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_NEXT,
		S_MACC,
		S_SQRI,
		S_MSQR,
		S_DONE
	} rsa_state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic mul_init;
		logic sqr_sel;
		logic mul_step;
		logic wb_acc;
		logic wb_base;
		logic finish;
	} rsa_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic range_err;
		logic exp_bit;
		logic exp_done;
		logic mul_last;
	} rsa_sts_t;

endpackage

// ===== rtl/rsa_modexp_64.sv =====
// Top level: 64-bit RSA modular exponentiation, square-and-multiply over exponent bits LSB first.
// On a range error the done strobe follows without any multiplication; otherwise each exponent bit
// costs a modular squaring of the base, plus a modular multiply into the accumulator when the bit is
// set, and the run time is set by the bit-serial multiplier at one bit per cycle.
// One item at a time; a new beat is taken in the cycle of the done strobe. Receiver cannot stall.
// Reset (arst_n low) clears the controller and restores modulus 2, exponents 1, encrypt mode.
module rsa_modexp_64 #(
	parameter int unsigned MODULUS_BITS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [rsa_pkg::DATA_W-1:0]    message_value,
	output logic                          done,
	output logic [rsa_pkg::DATA_W-1:0]    result_value,
	output logic                          range_error,
	input  logic                          cfg_we,
	input  logic [rsa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rsa_pkg::CFG_W-1:0]     cfg_wdata
);

	rsa_pkg::rsa_cmd_t cmd;
	rsa_pkg::rsa_sts_t sts;

	// Sequencer
	rsa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// Arithmetic and registers
	rsa_dp #(
		.W (MODULUS_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.message_value (message_value),
		.cmd           (cmd),
		.sts           (sts),
		.result_value  (result_value),
		.range_error   (range_error)
	);

endmodule

// ===== rtl/rsa_dp.sv =====
// Datapath: configuration registers, exponent shifter and bit-serial modular multiplier.
module rsa_dp #(
	parameter int unsigned W = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rsa_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rsa_pkg::CFG_W-1:0]         cfg_wdata,
	input  logic [rsa_pkg::DATA_W-1:0]        message_value,
	input  rsa_pkg::rsa_cmd_t                 cmd,
	output rsa_pkg::rsa_sts_t                 sts,
	output logic [rsa_pkg::DATA_W-1:0]        result_value,
	output logic                              range_error
);

	localparam int unsigned MCNT_W = $clog2(W);

	logic [W-1:0]                      mod_q;
	logic [rsa_pkg::EXP_BITS-1:0]      pub_q;
	logic [rsa_pkg::EXP_BITS-1:0]      priv_q;
	logic                              dec_q;

	logic [W-1:0]                      acc_q;
	logic [W-1:0]                      base_q;
	logic [rsa_pkg::EXP_BITS-1:0]      exp_q;
	logic [rsa_pkg::ECNT_W-1:0]        ecnt_q;
	logic                              err_q;

	logic [W-1:0]                      ma_q;
	logic [W-1:0]                      mb_q;
	logic [W-1:0]                      mres_q;
	logic [MCNT_W-1:0]                 mcnt_q;

	logic [rsa_pkg::DATA_W-1:0]        res_q;
	logic                              rerr_q;

	logic [W+1:0]                      t_sum;
	logic [W+1:0]                      two_n;
	logic [W+1:0]                      one_n;
	logic [W-1:0]                      step_res;
	logic                              in_err;

	// Config write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q  <= W'(2);
			pub_q  <= rsa_pkg::EXP_BITS'(1);
			priv_q <= rsa_pkg::EXP_BITS'(1);
			dec_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (rsa_pkg::rsa_cfg_idx_t'(cfg_index))
				rsa_pkg::CFG_MODULUS:  mod_q  <= cfg_wdata[W-1:0];
				rsa_pkg::CFG_PUB_EXP:  pub_q  <= cfg_wdata;
				rsa_pkg::CFG_PRIV_EXP: priv_q <= cfg_wdata;
				rsa_pkg::CFG_DECRYPT:  dec_q  <= cfg_wdata[0];
			endcase
		end
	end

	// Input range check against the modulus
	assign in_err = message_value >= rsa_pkg::DATA_W'(mod_q);

	// One multiplier step: res = 2*res + (bit ? a : 0), reduced from below 3n
	always_comb begin
		t_sum = {1'b0, mres_q, 1'b0} + {2'b00, (mb_q[W-1] ? ma_q : '0)};
		two_n = {1'b0, mod_q, 1'b0};
		one_n = {2'b00, mod_q};
		if (t_sum >= two_n) begin
			step_res = W'(t_sum - two_n);
		end else if (t_sum >= one_n) begin
			step_res = W'(t_sum - one_n);
		end else begin
			step_res = t_sum[W-1:0];
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			err_q  <= in_err;
			base_q <= message_value[W-1:0];
			acc_q  <= (mod_q == W'(1)) ? '0 : W'(1);
			exp_q  <= dec_q ? priv_q : pub_q;
			ecnt_q <= '0;
		end
		if (cmd.mul_init) begin
			ma_q   <= cmd.sqr_sel ? base_q : acc_q;
			mb_q   <= base_q;
			mres_q <= '0;
			mcnt_q <= '0;
		end
		if (cmd.mul_step) begin
			mres_q <= step_res;
			mb_q   <= {mb_q[W-2:0], 1'b0};
			mcnt_q <= mcnt_q + MCNT_W'(1);
		end
		if (cmd.wb_acc) begin
			acc_q <= step_res;
		end
		if (cmd.wb_base) begin
			base_q <= step_res;
			exp_q  <= {1'b0, exp_q[rsa_pkg::EXP_BITS-1:1]};
			ecnt_q <= ecnt_q + rsa_pkg::ECNT_W'(1);
		end
		if (cmd.finish) begin
			res_q  <= err_q ? '0 : rsa_pkg::DATA_W'(acc_q);
			rerr_q <= err_q;
		end
	end

	assign sts.range_err = err_q;
	assign sts.exp_bit   = exp_q[0];
	assign sts.exp_done  = (ecnt_q == rsa_pkg::ECNT_W'(rsa_pkg::EXP_BITS));
	assign sts.mul_last  = (mcnt_q == MCNT_W'(W - 1));

	assign result_value = res_q;
	assign range_error  = rerr_q;

endmodule

// ===== rtl/rsa_ctrl.sv =====
// Controller: sequences square-and-multiply over the exponent bits.
module rsa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  rsa_pkg::rsa_sts_t sts,
	output rsa_pkg::rsa_cmd_t cmd,
	output logic              busy,
	output logic              done
);

	rsa_pkg::rsa_state_t state_q;
	rsa_pkg::rsa_state_t state_nxt;
	logic                done_q;

	// State register and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rsa_pkg::S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= (state_q == rsa_pkg::S_DONE);
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			rsa_pkg::S_IDLE: begin
				if (start) state_nxt = rsa_pkg::S_NEXT;
			end
			rsa_pkg::S_NEXT: begin
				priority if (sts.range_err || sts.exp_done) state_nxt = rsa_pkg::S_DONE;
				else if (sts.exp_bit) state_nxt = rsa_pkg::S_MACC;
				else state_nxt = rsa_pkg::S_MSQR;
			end
			rsa_pkg::S_MACC: begin
				if (sts.mul_last) state_nxt = rsa_pkg::S_SQRI;
			end
			rsa_pkg::S_SQRI: state_nxt = rsa_pkg::S_MSQR;
			rsa_pkg::S_MSQR: begin
				if (sts.mul_last) state_nxt = rsa_pkg::S_NEXT;
			end
			rsa_pkg::S_DONE: state_nxt = rsa_pkg::S_IDLE;
			default: state_nxt = rsa_pkg::S_IDLE;
		endcase
	end

	// Command decode
	always_comb begin
		cmd = '0;
		unique case (state_q)
			rsa_pkg::S_IDLE: cmd.load = start;
			rsa_pkg::S_NEXT: begin
				if (!sts.range_err && !sts.exp_done) begin
					cmd.mul_init = 1'b1;
					cmd.sqr_sel  = !sts.exp_bit;
				end
			end
			rsa_pkg::S_MACC: begin
				cmd.mul_step = 1'b1;
				cmd.wb_acc   = sts.mul_last;
			end
			rsa_pkg::S_SQRI: begin
				cmd.mul_init = 1'b1;
				cmd.sqr_sel  = 1'b1;
			end
			rsa_pkg::S_MSQR: begin
				cmd.mul_step = 1'b1;
				cmd.wb_base  = sts.mul_last;
			end
			rsa_pkg::S_DONE: cmd.finish = 1'b1;
			default: cmd = '0;
		endcase
	end

	assign busy = (state_q != rsa_pkg::S_IDLE);
	assign done = done_q;

	// Checks
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("result strobe longer than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted beat did not raise busy");

	a_done_after: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == rsa_pkg::S_DONE)) else $error("strobe without finish");

	a_no_step_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !cmd.mul_step && !cmd.wb_acc && !cmd.wb_base)
		else $error("datapath step while idle");

endmodule

// ===== sim/rsa_modexp_64_checker.sv =====
`timescale 1ns / 100ps
// Checker for rsa_modexp_64: tracks key registers, predicts each result, compares done beats.
module rsa_modexp_64_checker #(
	parameter int unsigned MODULUS_BITS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  logic [rsa_pkg::DATA_W-1:0]    message_value,
	input  logic                          done,
	input  logic [rsa_pkg::DATA_W-1:0]    result_value,
	input  logic                          range_error,
	input  logic                          cfg_we,
	input  logic [rsa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rsa_pkg::CFG_W-1:0]     cfg_wdata,
	output int                            outstanding,
	output int                            errors
);
	import rsa_pkg::*;

	localparam logic [DATA_W-1:0] MOD_MASK = {DATA_W{1'b1}} >> (64 - MODULUS_BITS);

	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              range_err;
	} modexp_res_t;

	// Shadow copy of the key registers
	logic [DATA_W-1:0]   key_modulus;
	logic [EXP_BITS-1:0] key_pub_exp;
	logic [EXP_BITS-1:0] key_priv_exp;
	logic                key_decrypt;

	// Results still owed by the block, oldest first
	modexp_res_t pending_results[$];

	// Exact (a * b) mod n through a full 128-bit product
	function automatic logic [DATA_W-1:0] mul_mod(input logic [DATA_W-1:0] a,
			input logic [DATA_W-1:0] b, input logic [DATA_W-1:0] n);
		logic [2*DATA_W-1:0] prod;
		logic [2*DATA_W-1:0] rem;
		prod = {{DATA_W{1'b0}}, a} * {{DATA_W{1'b0}}, b};
		rem  = prod % {{DATA_W{1'b0}}, n};
		return rem[DATA_W-1:0];
	endfunction

	// Square-and-multiply, exponent bits taken LSB first
	function automatic modexp_res_t predict_modexp(input logic [DATA_W-1:0] x);
		logic [DATA_W-1:0]   n;
		logic [EXP_BITS-1:0] e;
		logic [DATA_W-1:0]   acc;
		logic [DATA_W-1:0]   base;
		modexp_res_t         r;
		int                  i;
		n = key_modulus;
		e = key_decrypt ? key_priv_exp : key_pub_exp;
		r.value     = '0;
		r.range_err = 1'b1;
		// value not below modulus (covers modulus zero)
		if (x >= n)
			return r;
		acc  = (n == 1) ? '0 : DATA_W'(1);
		base = x;
		for (i = 0; i < EXP_BITS; i++) begin
			if (e[i])
				acc = mul_mod(acc, base, n);
			base = mul_mod(base, base, n);
		end
		r.value     = acc;
		r.range_err = 1'b0;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] want);
		$display("%0t: %s mismatch: got %h, expected %h", $time, what, got, want);
		errors++;
	endtask

	// Watch config writes, accepted beats and done strobes
	always @(posedge clk or negedge arst_n) begin
		modexp_res_t want;
		if (!arst_n) begin
			key_modulus  <= 2;
			key_pub_exp  <= 1;
			key_priv_exp <= 1;
			key_decrypt  <= 1'b0;
			pending_results.delete();
			outstanding  <= 0;
			errors = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_MODULUS:  key_modulus  <= cfg_wdata & MOD_MASK;
					CFG_PUB_EXP:  key_pub_exp  <= cfg_wdata;
					CFG_PRIV_EXP: key_priv_exp <= cfg_wdata;
					CFG_DECRYPT:  key_decrypt  <= cfg_wdata[0];
					default: ;
				endcase
			end
			// done beat: match against the oldest prediction
			if (done) begin
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected done beat", result_value, '0);
				end else begin
					want = pending_results.pop_front();
					if (result_value !== want.value)
						report_mismatch("result_value", result_value, want.value);
					if (range_error !== want.range_err)
						report_mismatch("range_error", DATA_W'(range_error),
							DATA_W'(want.range_err));
				end
			end
			// accepted input beat
			if (start && !busy)
				pending_results.push_back(predict_modexp(message_value));
			outstanding <= pending_results.size();
		end
	end

endmodule

// ===== sim/rsa_modexp_64_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for rsa_modexp_64: clock, reset, key phases, message stimulus and verdict.
module rsa_modexp_64_tb;
	import rsa_pkg::*;

	localparam int unsigned MODULUS_BITS = 64;
	localparam int          IDLE_LIMIT   = 40000;
	localparam int          RANDOM_ITEMS = 100;
	localparam logic [63:0] ALL_ONES     = '1;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic [DATA_W-1:0] message_value = '0;
	logic              cfg_we = 1'b0;
	rsa_cfg_idx_t      cfg_index = CFG_MODULUS;
	logic [CFG_W-1:0]  cfg_wdata = '0;
	logic              busy;
	logic              done;
	logic [DATA_W-1:0] result_value;
	logic              range_error;
	int                outstanding;
	int                errors;
	int                idle_cycles = 0;
	bit                no_gaps = 1'b0;

	always #1 clk = ~clk;

	rsa_modexp_64 #(.MODULUS_BITS(MODULUS_BITS)) dut (
		.clk, .arst_n, .start, .busy, .message_value, .done, .result_value,
		.range_error, .cfg_we, .cfg_index, .cfg_wdata
	);

	rsa_modexp_64_checker #(.MODULUS_BITS(MODULUS_BITS)) u_checker (
		.clk, .arst_n, .start, .busy, .message_value, .done, .result_value,
		.range_error, .cfg_we, .cfg_index, .cfg_wdata, .outstanding, .errors
	);

	// Watchdog: cycles without any accepted beat, done strobe or config write
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("rsa_modexp_64 test failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Mostly back-to-back or short gaps, now and then a long one
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 4);
		return $urandom_range(20, 200);
	endfunction

	// One message beat; start stays high if the next beat follows at once
	task automatic send_message(input logic [63:0] value);
		int gap;
		gap = no_gaps ? 0 : pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			message_value <= rand64();
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		message_value <= value;
		do @(posedge clk); while (busy);
	endtask

	// Wait until every predicted result has come back
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0 || busy);
	endtask

	// Write all four key registers; call only when drained
	task automatic load_key(input logic [63:0] n, input logic [63:0] e,
			input logic [63:0] d, input logic mode);
		cfg_we <= 1'b1;
		cfg_index <= CFG_MODULUS;
		cfg_wdata <= n;
		@(posedge clk);
		cfg_index <= CFG_PUB_EXP;
		cfg_wdata <= e;
		@(posedge clk);
		cfg_index <= CFG_PRIV_EXP;
		cfg_wdata <= d;
		@(posedge clk);
		cfg_index <= CFG_DECRYPT;
		cfg_wdata <= {63'd0, mode};
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [63:0] pick_modulus();
		logic [63:0] n;
		case ($urandom_range(0, 4))
			0: n = $urandom_range(2, 65535);
			1: n = rand64() | 64'h8000_0000_0000_0000;
			2: n = ALL_ONES - $urandom_range(0, 3);
			default: n = rand64() >> $urandom_range(0, 62);
		endcase
		return (n < 2) ? 64'd2 : n;
	endfunction

	function automatic logic [63:0] pick_exponent();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return ALL_ONES;
			2: return 64'd65537;
			3: return $urandom_range(1, 255);
			default: return rand64();
		endcase
	endfunction

	// Mostly in-range messages, some at the edges, some out of range
	function automatic logic [63:0] pick_message(input logic [63:0] n);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 75)
			return rand64() % n;
		if (roll < 82)
			return n - 1;
		if (roll < 86)
			return $urandom_range(0, 1);
		if (roll < 90)
			return n;
		return n + rand64() % (64'd0 - n);
	endfunction

	initial begin
		logic [63:0] n;
		int          sent;
		int          phase_len;
		int          i;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset key: modulus 2, exponent 1
		send_message(64'd0);
		send_message(64'd1);
		send_message(64'd2);
		send_message(ALL_ONES);
		drain();

		// Modulus zero: everything out of range
		load_key(64'd0, 64'd5, 64'd7, 1'b0);
		send_message(64'd0);
		send_message(64'd123);
		drain();

		// Modulus one: zero in range, one out of range
		load_key(64'd1, 64'd3, 64'd3, 1'b1);
		send_message(64'd0);
		send_message(64'd1);
		drain();

		// Small textbook key pair, encrypt then decrypt
		load_key(64'd3233, 64'd17, 64'd2753, 1'b0);
		send_message(64'd65);
		drain();
		load_key(64'd3233, 64'd17, 64'd2753, 1'b1);
		send_message(64'd2790);
		send_message(64'd3232);
		send_message(64'd3233);
		drain();

		// Full-width modulus, all-ones exponent (slowest path)
		load_key(ALL_ONES, ALL_ONES, 64'd0, 1'b0);
		send_message(ALL_ONES - 1);
		send_message(64'd0);
		send_message(64'd1);
		send_message(ALL_ONES);
		drain();

		// Exponent zero gives one
		load_key(ALL_ONES, ALL_ONES, 64'd0, 1'b1);
		send_message(64'd12345);
		drain();

		// Random large odd modulus, standard public exponent
		n = rand64() | 64'h8000_0000_0000_0001;
		load_key(n, 64'd65537, rand64(), 1'b0);
		send_message(rand64() % n);
		send_message(n - 1);
		drain();

		// Random key phases
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			n = pick_modulus();
			load_key(n, pick_exponent(), pick_exponent(), 1'($urandom_range(0, 1)));
			no_gaps = ($urandom_range(0, 3) == 0);
			phase_len = $urandom_range(6, 16);
			for (i = 0; i < phase_len; i++)
				send_message(pick_message(n));
			sent += phase_len;
			drain();
		end
		no_gaps = 1'b0;

		// Catch any stray done beat
		repeat (20) @(posedge clk);
		if (errors == 0 && outstanding == 0)
			$display("rsa_modexp_64 test passed");
		else
			$display("rsa_modexp_64 test failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/rsa_pkg.sv
rtl/rsa_dp.sv
rtl/rsa_ctrl.sv
rtl/rsa_modexp_64.sv
sim/rsa_modexp_64_checker.sv
sim/rsa_modexp_64_tb.sv
